[hdl/mm4_pkg.sv]
package mm4_pkg;

    localparam int ELEMENT_WIDTH = 32;
    localparam int FRAC_BITS     = 16;
    localparam int PROD_WIDTH    = 2 * ELEMENT_WIDTH;
    localparam int SUM_WIDTH     = PROD_WIDTH + 2;
    localparam int DIM           = 4;

    localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
    localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
    // 1.0 on the diagonal, or the largest element when 1.0 does not fit
    localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_ONE =
        (FRAC_BITS >= ELEMENT_WIDTH - 1) ? ELEM_MAX : (ELEMENT_WIDTH'(1) << FRAC_BITS);

    typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_WIDTH-1:0]    prod_t;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_MUL   = 2'd1,
        KIND_XFORM = 2'd2
    } kind_t;

    typedef struct packed {
        elem_t value;
        logic  ovf;
    } lane_res_t;

endpackage

[hdl/mm4_in_if.sv]
interface mm4_in_if import mm4_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] row;
    elem_t      e0;
    elem_t      e1;
    elem_t      e2;
    elem_t      e3;

    modport source (output valid, kind, row, e0, e1, e2, e3, input ready);
    modport sink   (input valid, kind, row, e0, e1, e2, e3, output ready);
endinterface

[hdl/mm4_out_if.sv]
interface mm4_out_if import mm4_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t r0;
    elem_t r1;
    elem_t r2;
    elem_t r3;
    logic  overflow;

    modport source (output valid, r0, r1, r2, r3, overflow, input ready);
    modport sink   (input valid, r0, r1, r2, r3, overflow, output ready);
endinterface

[hdl/mm4_sat.sv]
module mm4_sat import mm4_pkg::*;
(
    input  prod_t     prod [DIM],
    output lane_res_t res
);

    logic signed [SUM_WIDTH-1:0] sum;
    logic signed [SUM_WIDTH-1:0] shifted;
    logic                        fits;

    always_comb
    begin
        sum = SUM_WIDTH'(prod[0]) + SUM_WIDTH'(prod[1])
            + SUM_WIDTH'(prod[2]) + SUM_WIDTH'(prod[3]);
        // floor shift, then every bit above the element must copy its sign
        shifted = sum >>> FRAC_BITS;
        fits = (shifted[SUM_WIDTH-1:ELEMENT_WIDTH-1] == '0)
            || (shifted[SUM_WIDTH-1:ELEMENT_WIDTH-1] == '1);
        if (fits)
        begin
            res.value = shifted[ELEMENT_WIDTH-1:0];
            res.ovf   = 1'b0;
        end
        else
        begin
            res.value = sum[SUM_WIDTH-1] ? ELEM_MIN : ELEM_MAX;
            res.ovf   = 1'b1;
        end
    end

endmodule

[hdl/matrix4_multiply_transform.sv]
// 4x4 fixed-point matrix multiply and vector transform.
//
// item channel: one beat per load, multiply or transform. A load beat writes
// row "row" of the stored right-hand matrix at the edge it is accepted and
// returns nothing; a beat with the unused kind code is dropped. A multiply
// beat returns one row of left * stored; a transform beat returns (x,y,z)
// times the upper-left 3x3 with r3 = 0.
// result channel: r0..r3 and overflow, set when any element saturated.
// An accepted item passes the input register, the product register and the
// result register in that order. Throughput is one item per cycle while the
// receiver does not stall, set by the 16 parallel element multipliers.
// A beat issued after a load sees the new row; one issued before does not.
// Reset clears the pipeline and sets the stored matrix to identity.
// When the receiver stalls, the result register holds and the stages behind
// it keep filling; item.ready drops only once all three stages are full.
module matrix4_multiply_transform import mm4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mm4_in_if.sink    item,
    mm4_out_if.source result
);

    elem_t     matrix_reg [DIM][DIM];

    logic      s0_valid_reg;
    logic      s0_xform_reg;
    elem_t     s0_elem_reg [DIM];

    logic      s1_valid_reg;
    logic      s1_xform_reg;
    prod_t     prod_reg [DIM][DIM];
    prod_t     prod_next [DIM][DIM];
    prod_t     col_prod [DIM][DIM];

    logic      out_valid_reg;
    elem_t     out_value_reg [DIM];
    logic      out_ovf_reg;

    lane_res_t lane_res [DIM];
    logic      ovf_next;

    logic      out_free;
    logic      s1_free;
    logic      s0_free;
    logic      accept;
    logic      is_compute;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_free    = !s1_valid_reg || out_free;
    assign s0_free    = !s0_valid_reg || s1_free;
    assign item.ready = s0_free;
    assign accept     = item.valid && s0_free;
    assign is_compute = (item.kind == KIND_MUL) || (item.kind == KIND_XFORM);

    // stored matrix: written by load beats only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    matrix_reg[r][c] <= (r == c) ? ELEM_ONE : '0;
                end
            end
        end
        else if (accept && item.kind == KIND_LOAD)
        begin
            matrix_reg[item.row][0] <= item.e0;
            matrix_reg[item.row][1] <= item.e1;
            matrix_reg[item.row][2] <= item.e2;
            matrix_reg[item.row][3] <= item.e3;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_free)
        begin
            s0_valid_reg <= accept && is_compute;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_xform_reg   <= (item.kind == KIND_XFORM);
            s0_elem_reg[0] <= item.e0;
            s0_elem_reg[1] <= item.e1;
            s0_elem_reg[2] <= item.e2;
            // drop the fourth term for a transform
            s0_elem_reg[3] <= (item.kind == KIND_XFORM) ? '0 : item.e3;
        end
    end

    // product stage: element k of the row times stored row k, column j
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                prod_next[k][j] = PROD_WIDTH'(s0_elem_reg[k]) * PROD_WIDTH'(matrix_reg[k][j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && s0_valid_reg)
        begin
            s1_xform_reg <= s0_xform_reg;
            prod_reg     <= prod_next;
        end
    end

    // sum, shift and saturate one column per lane
    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        for (genvar k = 0; k < DIM; k++)
        begin : g_term
            assign col_prod[j][k] = prod_reg[k][j];
        end

        mm4_sat u_sat
        (
            .prod (col_prod[j]),
            .res  (lane_res[j])
        );
    end

    assign ovf_next = lane_res[0].ovf || lane_res[1].ovf || lane_res[2].ovf
                   || (lane_res[3].ovf && !s1_xform_reg);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_value_reg[0] <= lane_res[0].value;
            out_value_reg[1] <= lane_res[1].value;
            out_value_reg[2] <= lane_res[2].value;
            out_value_reg[3] <= s1_xform_reg ? '0 : lane_res[3].value;
            out_ovf_reg      <= ovf_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.r0       = out_value_reg[0];
    assign result.r1       = out_value_reg[1];
    assign result.r2       = out_value_reg[2];
    assign result.r3       = out_value_reg[3];
    assign result.overflow = out_ovf_reg;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("item not ready while result register is empty");

    a_result_from_products: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a product beat");

    a_compute_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.kind == KIND_MUL || item.kind == KIND_XFORM))
        |=> s0_valid_reg)
        else $error("accepted compute beat was lost");

endmodule

[tb/tb_matrix4_multiply_transform.sv]
`timescale 1ns / 1ps

module tb_matrix4_multiply_transform import mm4_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         HOLD_CYCLES   = 64;
    localparam int         PHASE_ITEMS   = 185;
    localparam int         DRAIN_CYCLES  = 12;
    localparam int         MAX_PRINTED   = 100;

    typedef logic signed [2*ELEMENT_WIDTH+3:0] wide_sum_t;

    typedef struct {
        elem_t r [DIM];
        logic  ovf;
    } product_row_t;

    class mm4_scoreboard;
        elem_t        right_matrix [DIM*DIM];
        product_row_t pending_rows [$];
        int           errors;
        int           rows_checked;
        int           loads_seen;
        int           ignored_seen;
        int           saturated_seen;

        function new();
            for (int i = 0; i < DIM*DIM; i++)
                right_matrix[i] = (i % (DIM + 1) == 0) ? ELEM_ONE : elem_t'(0);
            errors = 0;
            rows_checked = 0;
            loads_seen = 0;
            ignored_seen = 0;
            saturated_seen = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Exact sum of products, arithmetic shift, then saturate per lane.
        function product_row_t multiply_row(logic [1:0] kind, elem_t v [DIM]);
            product_row_t res;
            wide_sum_t    acc;
            int           terms;
            terms = (kind == KIND_MUL) ? DIM : 3;
            res.ovf = 1'b0;
            for (int j = 0; j < DIM; j++)
            begin
                if (kind == KIND_XFORM && j == DIM - 1)
                begin
                    res.r[j] = '0;
                end
                else
                begin
                    acc = '0;
                    for (int k = 0; k < terms; k++)
                        acc += wide_sum_t'(v[k]) * wide_sum_t'(right_matrix[k*DIM + j]);
                    acc = acc >>> FRAC_BITS;
                    if (acc > wide_sum_t'(ELEM_MAX))
                    begin
                        res.r[j] = ELEM_MAX;
                        res.ovf = 1'b1;
                    end
                    else if (acc < wide_sum_t'(ELEM_MIN))
                    begin
                        res.r[j] = ELEM_MIN;
                        res.ovf = 1'b1;
                    end
                    else
                    begin
                        res.r[j] = elem_t'(acc);
                    end
                end
            end
            return res;
        endfunction

        function void note_item(logic [1:0] kind, logic [1:0] row,
                                elem_t v0, elem_t v1, elem_t v2, elem_t v3);
            elem_t v [DIM];
            v = '{v0, v1, v2, v3};
            case (kind)
                KIND_LOAD:
                begin
                    for (int k = 0; k < DIM; k++)
                        right_matrix[row*DIM + k] = v[k];
                    loads_seen++;
                end
                KIND_MUL, KIND_XFORM:
                begin
                    pending_rows.push_back(multiply_row(kind, v));
                end
                default:
                begin
                    ignored_seen++;
                end
            endcase
        endfunction

        task check_result(elem_t g0, elem_t g1, elem_t g2, elem_t g3, logic g_ovf);
            elem_t        got [DIM];
            product_row_t want;
            got = '{g0, g1, g2, g3};
            if (pending_rows.size() == 0)
            begin
                report("result beat with no row pending");
            end
            else
            begin
                want = pending_rows.pop_front();
                for (int j = 0; j < DIM; j++)
                    if (got[j] !== want.r[j])
                        report($sformatf("row %0d r%0d: got %h, want %h",
                                         rows_checked, j, got[j], want.r[j]));
                if (g_ovf !== want.ovf)
                    report($sformatf("row %0d overflow: got %b, want %b",
                                     rows_checked, g_ovf, want.ovf));
                if (want.ovf)
                    saturated_seen++;
                rows_checked++;
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    mm4_in_if  item_if ();
    mm4_out_if result_if ();

    matrix4_multiply_transform i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    mm4_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int items_sent     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
                sb.note_item(item_if.kind, item_if.row,
                             item_if.e0, item_if.e1, item_if.e2, item_if.e3);
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.r0, result_if.r1, result_if.r2,
                                result_if.r3, result_if.overflow);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("matrix4_multiply_transform test failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [1:0] kind, logic [1:0] row,
                             elem_t v0, elem_t v1, elem_t v2, elem_t v3);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.kind  <= kind;
        item_if.row   <= row;
        item_if.e0    <= v0;
        item_if.e1    <= v1;
        item_if.e2    <= v2;
        item_if.e3    <= v3;
        do
            @(posedge clk);
        while (!item_if.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_uniform(elem_t v);
        for (int r = 0; r < DIM; r++)
            send_item(KIND_LOAD, 2'(r), v, v, v, v);
    endtask

    function automatic elem_t rand_elem();
        case ($urandom_range(9))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return '0;
            3:       return ($urandom_range(1) != 0) ? ELEM_ONE : -ELEM_ONE;
            4, 5:    return elem_t'({$urandom(), $urandom()});
            // values within a few units, where sums rarely saturate
            default: return elem_t'($urandom_range(1 << (FRAC_BITS + 3)))
                            - elem_t'(1 << (FRAC_BITS + 2));
        endcase
    endfunction

    task automatic random_item();
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(99);
        if (pick < 25)
            kind = KIND_LOAD;
        else if (pick < 60)
            kind = KIND_MUL;
        else if (pick < 92)
            kind = KIND_XFORM;
        else
            kind = KIND_UNUSED;
        send_item(kind, 2'($urandom_range(3)), rand_elem(), rand_elem(),
                  rand_elem(), rand_elem());
    endtask

    initial
    begin
        int idle_plan [4][2];
        idle_plan = '{'{0, 0}, '{46, 0}, '{0, 46}, '{16, 16}};
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.kind  = KIND_LOAD;
        item_if.row   = '0;
        item_if.e0    = '0;
        item_if.e1    = '0;
        item_if.e2    = '0;
        item_if.e3    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity after reset, extremes pass straight through
        send_item(KIND_MUL, 2'd1, ELEM_MAX, ELEM_MIN, '0, -elem_t'(1));
        send_item(KIND_XFORM, 2'd3, ELEM_MIN, ELEM_MAX, ELEM_ONE, ELEM_MAX);
        send_item(KIND_UNUSED, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
        send_item(KIND_MUL, 2'd2, elem_t'(1), -elem_t'(1), ELEM_ONE, -ELEM_ONE);
        // saturate high and low
        load_uniform(ELEM_MAX);
        send_item(KIND_MUL, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
        send_item(KIND_MUL, 2'd0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        send_item(KIND_XFORM, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MIN);
        load_uniform(ELEM_MIN);
        send_item(KIND_MUL, 2'd3, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        send_item(KIND_XFORM, 2'd1, ELEM_MIN, '0, ELEM_MAX, ELEM_MIN);
        // one lsb in every element: check the shift rounds toward minus infinity
        load_uniform(elem_t'(1));
        send_item(KIND_MUL, 2'd0, -elem_t'(1), '0, '0, '0);
        send_item(KIND_MUL, 2'd0, elem_t'(1), '0, '0, '0);
        // ignored kind must leave the stored matrix untouched
        send_item(KIND_UNUSED, 2'd2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        send_item(KIND_XFORM, 2'd2, ELEM_ONE, -ELEM_ONE, ELEM_MAX, ELEM_MAX);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            // fill the pipeline against a held-off receiver
            if (p == 0)
                hold_request++;
            repeat (PHASE_ITEMS) random_item();
        end
        item_if.valid <= 1'b0;
        recv_stall_pct = 0;

        while (sb.pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d loads, %0d with the unused kind.",
                 items_sent, sb.loads_seen, sb.ignored_seen);
        $display("Checked %0d result rows, %0d of them saturated, %0d errors.",
                 sb.rows_checked, sb.saturated_seen, sb.errors);
        if (sb.errors == 0)
            $display("matrix4_multiply_transform test passed");
        else
            $display("matrix4_multiply_transform test failed");
        $finish;
    end

endmodule
